[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define CHK_IMPLY(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
    else $error("check failed");
`endif

[sv/vdk7_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package vdk7_pkg;
  localparam int NUM_STATES     = 64;
  localparam int TRACE_DEPTH_D  = 35;
  localparam int METRIC_BITS_D  = 16;
  localparam logic [11:0] METRIC_CAP = 12'hFFF;
  localparam logic [6:0] POLY_ONE_RST = 7'h79;
  localparam logic [6:0] POLY_TWO_RST = 7'h5B;
  localparam logic [0:0] REG_POLY_ONE = 1'b0;
  localparam logic [0:0] REG_POLY_TWO = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACS, ST_DECIDE, ST_TB_RD, ST_TB_WT, ST_EMIT
  } vdk7_state_t;

  typedef struct packed {
    logic [1:0] rx;
    logic [6:0] poly_one;
    logic [6:0] poly_two;
  } vdk7_acs_ctl_t;
endpackage
`default_nettype wire

[sv/vdk7_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface vdk7_sym_if;
  logic       valid;
  logic       ready;
  logic [1:0] rx_pair;
  logic       frame_end;
  modport source (output valid, rx_pair, frame_end, input ready);
  modport sink (input valid, rx_pair, frame_end, output ready);
endinterface

interface vdk7_bit_if;
  logic valid;
  logic ready;
  logic info_bit;
  logic frame_end_out;
  modport source (output valid, info_bit, frame_end_out, input ready);
  modport sink (input valid, info_bit, frame_end_out, output ready);
endinterface
`default_nettype wire

[sv/viterbi_decoder_k7_r12_hard_unit.sv]
// K=7 rate 1/2 hard-decision Viterbi decoder, 64 states.
// in_ch: one beat per received dibit (rx_pair, frame_end).
// out_ch: zero or one decoded bit per input beat (info_bit, frame_end_out).
// cfg_*: write generator taps (index 0 first, 1 second) while idle.
// Each beat runs add-compare-select for all 64 states through one shared unit,
// one state per cycle, then a decide step. When a bit is due, a traceback
// of n = min(count, TRACE_DEPTH)-1 steps follows, each a registered survivor
// memory read and then a shift of the read bit into the state, then a
// closing check and an emit step. in_ready is low from an accepted beat until
// the block is back in idle, so a beat is taken only after the last is through.
// The bit shows on out_ch from the output register once the emit step runs.
// A finished bit sits in an output register; the next beat is accepted
// while it waits, and the block holds before emitting if out_ch still stalls.
// Reset (synchronous rst_n) restores frame start metrics, counters and taps;
// the survivor memory needs no clearing. frame_end also restarts the frame.
`timescale 1ns / 1ps
`default_nettype none
module viterbi_decoder_k7_r12_hard_unit
  import vdk7_pkg::*;
#(
  parameter int TRACE_DEPTH = TRACE_DEPTH_D,
  parameter int METRIC_BITS = METRIC_BITS_D
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [6:0] cfg_wdata,
  vdk7_sym_if.sink        in_ch,
  vdk7_bit_if.source      out_ch
);
  localparam int SLOT_W = $clog2(TRACE_DEPTH);
  localparam int CNT_W  = $clog2(TRACE_DEPTH + 1);
  localparam int SV_DEPTH = TRACE_DEPTH * NUM_STATES;
  localparam int SV_AW = SLOT_W + 6;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TRACE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TRACE_DEPTH);

  vdk7_state_t state_r, state_nxt;
  logic [6:0] poly_one_r, poly_two_r;
  logic [1:0] rx_r;
  logic last_r;
  logic [5:0] ns_r, ns_nxt;
  logic bank_r, bank_nxt, fresh_r, fresh_nxt;
  logic [METRIC_BITS-1:0] min_prev_r, min_prev_nxt, min_val_r, min_val_nxt;
  logic [5:0] min_idx_r, min_idx_nxt, st_r, st_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt, rem_r, rem_nxt, seen_inc;
  logic out_valid_r, out_valid_nxt, out_bit_r, out_bit_nxt, out_last_r, out_last_nxt;

  logic [METRIC_BITS-1:0] me0 [32];
  logic [METRIC_BITS-1:0] mo0 [32];
  logic [METRIC_BITS-1:0] me1 [32];
  logic [METRIC_BITS-1:0] mo1 [32];
  logic sv_mem [SV_DEPTH];
  logic sv_q;
  logic [SV_AW-1:0] sv_raddr;

  logic [METRIC_BITS-1:0] raw0, raw1, pm0, pm1, best;
  logic pred, acs_we, sv_re;
  vdk7_acs_ctl_t acs_ctl;

  assign acs_ctl = '{rx: rx_r, poly_one: poly_one_r, poly_two: poly_two_r};

  always_comb begin
    raw0 = bank_r ? me1[ns_r[4:0]] : me0[ns_r[4:0]];
    raw1 = bank_r ? mo1[ns_r[4:0]] : mo0[ns_r[4:0]];
    if (fresh_r) begin
      pm0 = (ns_r[4:0] == 5'd0) ? '0 : METRIC_BITS'(METRIC_CAP);
      pm1 = METRIC_BITS'(METRIC_CAP);
    end else begin
      pm0 = raw0 - min_prev_r;
      pm1 = raw1 - min_prev_r;
    end
  end

  vdk7_acs #(.METRIC_BITS(METRIC_BITS)) u_acs (
    .ctl(acs_ctl), .ns(ns_r), .pm0(pm0), .pm1(pm1), .best(best), .pred(pred)
  );

  assign acs_we = (state_r == ST_ACS);
  assign sv_raddr = {rd_r, st_r};

  always_ff @(posedge clk) begin
    if (acs_we) begin
      if (bank_r) begin
        if (ns_r[0]) mo0[ns_r[5:1]] <= best;
        else me0[ns_r[5:1]] <= best;
      end else begin
        if (ns_r[0]) mo1[ns_r[5:1]] <= best;
        else me1[ns_r[5:1]] <= best;
      end
      sv_mem[{slot_r, ns_r}] <= pred;
    end
    if (sv_re) begin
      sv_q <= sv_mem[sv_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_one_r <= POLY_ONE_RST;
      poly_two_r <= POLY_TWO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLY_ONE: poly_one_r <= cfg_wdata;
        REG_POLY_TWO: poly_two_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bank_r <= 1'b0;
      fresh_r <= 1'b1;
      slot_r <= '0;
      seen_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bank_r <= bank_nxt;
      fresh_r <= fresh_nxt;
      slot_r <= slot_nxt;
      seen_r <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      rx_r <= in_ch.rx_pair;
      last_r <= in_ch.frame_end;
    end
    ns_r <= ns_nxt;
    min_prev_r <= min_prev_nxt;
    min_val_r <= min_val_nxt;
    min_idx_r <= min_idx_nxt;
    st_r <= st_nxt;
    rd_r <= rd_nxt;
    rem_r <= rem_nxt;
    out_bit_r <= out_bit_nxt;
    out_last_r <= out_last_nxt;
  end

  assign seen_inc = (seen_r < CNT_MAX) ? seen_r + 1'b1 : seen_r;

  always_comb begin
    state_nxt = state_r;
    ns_nxt = ns_r;
    bank_nxt = bank_r;
    fresh_nxt = fresh_r;
    min_prev_nxt = min_prev_r;
    min_val_nxt = min_val_r;
    min_idx_nxt = min_idx_r;
    st_nxt = st_r;
    rd_nxt = rd_r;
    rem_nxt = rem_r;
    slot_nxt = slot_r;
    seen_nxt = seen_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_bit_nxt = out_bit_r;
    out_last_nxt = out_last_r;
    sv_re = 1'b0;
    in_ch.ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ns_nxt = '0;
        min_val_nxt = METRIC_BITS'(METRIC_CAP);
        min_idx_nxt = '0;
        if (in_ch.valid) state_nxt = ST_ACS;
      end
      ST_ACS: begin
        if (best < min_val_r) begin
          min_val_nxt = best;
          min_idx_nxt = ns_r;
        end
        ns_nxt = ns_r + 1'b1;
        if (ns_r == 6'd63) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        seen_nxt = seen_inc;
        slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        min_prev_nxt = min_val_r;
        fresh_nxt = 1'b0;
        bank_nxt = !bank_r;
        st_nxt = min_idx_r;
        rd_nxt = slot_r;
        rem_nxt = seen_inc - 1'b1;
        state_nxt = (seen_inc == CNT_MAX || last_r) ? ST_TB_RD : ST_IDLE;
      end
      ST_TB_RD: begin
        if (rem_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          sv_re = 1'b1;
          state_nxt = ST_TB_WT;
        end
      end
      ST_TB_WT: begin
        st_nxt = {st_r[4:0], sv_q};
        rd_nxt = (rd_r == '0) ? SLOT_LAST : rd_r - 1'b1;
        rem_nxt = rem_r - 1'b1;
        state_nxt = ST_TB_RD;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt = st_r[5];
          out_last_nxt = last_r;
          if (last_r) begin
            fresh_nxt = 1'b1;
            slot_nxt = '0;
            seen_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.info_bit = out_bit_r;
  assign out_ch.frame_end_out = out_last_r;
endmodule
`default_nettype wire

[sv/vdk7_acs.sv]
`timescale 1ns / 1ps
`default_nettype none
module vdk7_acs
  import vdk7_pkg::*;
#(
  parameter int METRIC_BITS = METRIC_BITS_D
) (
  input  wire vdk7_acs_ctl_t          ctl,
  input  wire logic [5:0]             ns,
  input  wire logic [METRIC_BITS-1:0] pm0,
  input  wire logic [METRIC_BITS-1:0] pm1,
  output logic [METRIC_BITS-1:0]      best,
  output logic                        pred
);
  logic [6:0] reg0, reg1;
  logic [1:0] d0, d1, x0, x1;
  logic [METRIC_BITS-1:0] m0, m1, cap;

  always_comb begin
    reg0 = {ns[4:0], 1'b0, ns[5]};
    reg1 = {ns[4:0], 1'b1, ns[5]};
    d0 = {^(reg0 & ctl.poly_one), ^(reg0 & ctl.poly_two)};
    d1 = {^(reg1 & ctl.poly_one), ^(reg1 & ctl.poly_two)};
    x0 = d0 ^ ctl.rx;
    x1 = d1 ^ ctl.rx;
    m0 = pm0 + METRIC_BITS'(x0[0]) + METRIC_BITS'(x0[1]);
    m1 = pm1 + METRIC_BITS'(x1[0]) + METRIC_BITS'(x1[1]);
    cap = METRIC_BITS'(METRIC_CAP);
    best = cap;
    pred = 1'b0;
    if (m0 < best) begin
      best = m0;
    end
    if (m1 < best) begin
      best = m1;
      pred = 1'b1;
    end
  end
endmodule
`default_nettype wire

[sv/vdk7_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vdk7_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_bit,
  input wire logic out_last
);
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `CHK_NEXT(a_no_bit_right_after_accept, clk, rst_n, in_valid && in_ready, !$rose(out_valid))
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CHK_NEXT(a_out_data_hold, clk, rst_n, out_valid && !out_ready, $stable({out_bit, out_last}))
  `CHK_IMPLY(a_rst_quiet, clk, 1'b1, $past(!rst_n), !out_valid)
endmodule

bind viterbi_decoder_k7_r12_hard_unit vdk7_checker u_vdk7_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_bit(out_ch.info_bit), .out_last(out_ch.frame_end_out)
);
`default_nettype wire
